// ----- design/pte_pkg.sv -----
// Package for the polynomial term store and evaluator.
// Holds sizes, operation and status codes, controller/datapath structs and
// the circular-address helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pte_pkg;

  localparam int MAX_TERMS   = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int POWER_WIDTH = 8;
  localparam int AW          = $clog2(MAX_TERMS);
  localparam int CW          = $clog2(MAX_TERMS + 1);
  localparam int EW          = VALUE_WIDTH + POWER_WIDTH;

  typedef enum logic [2:0] {
    FN_APPEND   = 3'd0,
    FN_INSERT   = 3'd1,
    FN_POP_HEAD = 3'd2,
    FN_POP_TAIL = 3'd3,
    FN_DELETE   = 3'd4,
    FN_READ     = 3'd5,
    FN_EVAL     = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_done;
    logic del_issue;
    logic del_chk;
    logic del_done;
    logic ev_issue;
    logic ev_load;
    logic ev_pow;
    logic ev_mul;
    logic ev_add;
    logic ev_done;
    logic push;
  } pte_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       full;
    logic       empty;
    logic       oob;
    logic       i_done;
    logic       e_zero;
    logic       out_busy;
  } pte_stat_t;

  // Physical slot of logical position off in the ring that starts at base.
  function automatic logic [AW-1:0] pte_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(MAX_TERMS)) s = s - (CW+1)'(MAX_TERMS);
    return s[AW-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/pte_if.sv -----
// Valid/ready channel interfaces for the term store input and result beats.
// Depends on pte_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pte_in_if;
  import pte_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    func;
  logic signed [VALUE_WIDTH-1:0] coef_in;
  logic [POWER_WIDTH-1:0]        power_in;
  logic signed [VALUE_WIDTH-1:0] arg_in;
  logic [POWER_WIDTH-1:0]        index_in;
  modport source (output valid, func, coef_in, power_in, arg_in, index_in, input ready);
  modport sink (input valid, func, coef_in, power_in, arg_in, index_in, output ready);
endinterface

interface pte_out_if;
  import pte_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic signed [VALUE_WIDTH-1:0] value_out;
  logic [POWER_WIDTH-1:0]        power_out;
  logic                          overflow;
  logic [CW-1:0]                 term_count_out;
  modport source (output valid, status, value_out, power_out, overflow, term_count_out,
                  input ready);
  modport sink (input valid, status, value_out, power_out, overflow, term_count_out,
                output ready);
endinterface
`default_nettype wire

// ----- design/pte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/pte_ctrl.sv -----
// Controller state machine for the term store: sequences list walks and
// the evaluation loop. Depends on pte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pte_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pte_pkg::pte_stat_t stat,
  output pte_pkg::pte_cmd_t       cmd
);
  import pte_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_EXEC    = 11'b000_0000_0010,
    S_RD_WAIT = 11'b000_0000_0100,
    S_DEL_RD  = 11'b000_0000_1000,
    S_DEL_CHK = 11'b000_0001_0000,
    S_EV_RD   = 11'b000_0010_0000,
    S_EV_LOAD = 11'b000_0100_0000,
    S_EV_POW  = 11'b000_1000_0000,
    S_EV_MUL  = 11'b001_0000_0000,
    S_EV_ADD  = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
        if (stat.func == FN_READ && !stat.oob) state_nxt = S_RD_WAIT;
        if (stat.func == FN_DELETE && !stat.empty) state_nxt = S_DEL_RD;
        if (stat.func == FN_EVAL) state_nxt = S_EV_RD;
      end
      S_RD_WAIT: begin
        cmd.rd_done = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DEL_RD: begin
        if (stat.i_done) begin
          cmd.del_done = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.del_issue = 1'b1;
          state_nxt     = S_DEL_CHK;
        end
      end
      S_DEL_CHK: begin
        cmd.del_chk = 1'b1;
        state_nxt   = S_DEL_RD;
      end
      S_EV_RD: begin
        if (stat.i_done) begin
          cmd.ev_done = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.ev_issue = 1'b1;
          state_nxt    = S_EV_LOAD;
        end
      end
      S_EV_LOAD: begin
        cmd.ev_load = 1'b1;
        state_nxt   = S_EV_POW;
      end
      S_EV_POW: begin
        if (stat.e_zero) begin
          state_nxt = S_EV_MUL;
        end else begin
          cmd.ev_pow = 1'b1;
        end
      end
      S_EV_MUL: begin
        cmd.ev_mul = 1'b1;
        state_nxt  = S_EV_ADD;
      end
      S_EV_ADD: begin
        cmd.ev_add = 1'b1;
        state_nxt  = S_EV_RD;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/pte_datapath.sv -----
// Datapath of the term store: ring-addressed term RAM, shared signed
// multiplier, accumulator and the result/output registers.
// Depends on pte_pkg and pte_ram.
`timescale 1ns / 1ps
`default_nettype none
module pte_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire pte_pkg::pte_cmd_t                      cmd,
  output pte_pkg::pte_stat_t                          stat,
  input  wire logic [2:0]                             in_func,
  input  wire logic signed [pte_pkg::VALUE_WIDTH-1:0] in_coef,
  input  wire logic [pte_pkg::POWER_WIDTH-1:0]        in_power,
  input  wire logic signed [pte_pkg::VALUE_WIDTH-1:0] in_arg,
  input  wire logic [pte_pkg::POWER_WIDTH-1:0]        in_index,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [1:0]                                  out_status,
  output logic signed [pte_pkg::VALUE_WIDTH-1:0]      out_value,
  output logic [pte_pkg::POWER_WIDTH-1:0]             out_power,
  output logic                                        out_overflow,
  output logic [pte_pkg::CW-1:0]                      out_count
);
  import pte_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int PW = POWER_WIDTH;

  logic [AW-1:0]        head_r;
  logic [CW-1:0]        count_r;
  logic                 out_valid_r;
  logic [2:0]           func_r;
  logic signed [VW-1:0] coef_r, arg_r;
  logic [PW-1:0]        pw_r, idx_r, e_r;
  logic [CW-1:0]        i_r, j_r;
  logic signed [VW-1:0] acc_r, tcoef_r, term_r, sum_r;
  logic                 povf_r, ovf_r;
  logic [1:0]           res_status_r;
  logic signed [VW-1:0] res_value_r;
  logic [PW-1:0]        res_power_r;
  logic                 res_ovf_r;
  logic [1:0]           out_status_r;
  logic signed [VW-1:0] out_value_r;
  logic [PW-1:0]        out_power_r;
  logic                 out_ovf_r;
  logic [CW-1:0]        out_count_r;

  logic                 full, empty, keep;
  logic                 we, re;
  logic [AW-1:0]        waddr, raddr, head_dec;
  logic [EW-1:0]        wdata, rdata;
  logic signed [VW-1:0] rd_coef;
  logic [PW-1:0]        rd_pow;
  logic signed [VW-1:0] mul_a;
  logic signed [2*VW-1:0] prod;
  logic                 movf;
  logic signed [VW-1:0] sum_add;
  logic                 aovf;

  assign full     = (count_r == CW'(MAX_TERMS));
  assign empty    = (count_r == '0);
  assign rd_coef  = rdata[EW-1:PW];
  assign rd_pow   = rdata[PW-1:0];
  assign keep     = (rd_coef != arg_r);
  assign head_dec = (head_r == '0) ? AW'(MAX_TERMS - 1) : head_r - AW'(1);

  // One shared signed multiplier: point powers, then coefficient times power.
  assign mul_a   = cmd.ev_mul ? tcoef_r : arg_r;
  assign prod    = mul_a * acc_r;
  assign movf    = !((&prod[2*VW-1:VW-1]) || !(|prod[2*VW-1:VW-1]));
  assign sum_add = sum_r + term_r;
  assign aovf    = (sum_r[VW-1] == term_r[VW-1]) && (sum_add[VW-1] != sum_r[VW-1]);

  always_comb begin
    stat          = '0;
    stat.func     = func_r;
    stat.full     = full;
    stat.empty    = empty;
    stat.oob      = (int'(idx_r) >= int'(count_r));
    stat.i_done   = (i_r == count_r);
    stat.e_zero   = (e_r == '0);
    stat.out_busy = out_valid_r && !out_ready;
  end

  always_comb begin
    we    = 1'b0;
    waddr = pte_wrap(head_r, count_r);
    wdata = {coef_r, pw_r};
    if (cmd.exec && !full && func_r == FN_APPEND) we = 1'b1;
    if (cmd.exec && !full && func_r == FN_INSERT) begin
      we    = 1'b1;
      waddr = head_dec;
    end
    if (cmd.del_chk && keep) begin
      we    = 1'b1;
      waddr = pte_wrap(head_r, j_r);
      wdata = rdata;
    end
    re    = cmd.exec || cmd.del_issue || cmd.ev_issue;
    raddr = cmd.exec ? pte_wrap(head_r, CW'(idx_r)) : pte_wrap(head_r, i_r);
  end

  pte_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_TERMS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.exec) begin
        case (func_r)
          FN_APPEND: if (!full) count_r <= count_r + CW'(1);
          FN_INSERT: begin
            if (!full) begin
              head_r  <= head_dec;
              count_r <= count_r + CW'(1);
            end
          end
          FN_POP_HEAD: begin
            if (!empty) begin
              head_r  <= pte_wrap(head_r, CW'(1));
              count_r <= count_r - CW'(1);
            end
          end
          FN_POP_TAIL: if (!empty) count_r <= count_r - CW'(1);
          default: ;
        endcase
      end
      if (cmd.del_done) count_r <= j_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      coef_r <= in_coef;
      pw_r   <= in_power;
      arg_r  <= in_arg;
      idx_r  <= in_index;
    end
    if (cmd.exec) begin
      res_status_r <= ST_OK;
      res_value_r  <= '0;
      res_power_r  <= '0;
      res_ovf_r    <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      sum_r        <= '0;
      ovf_r        <= 1'b0;
      case (func_r)
        FN_APPEND, FN_INSERT: if (full) res_status_r <= ST_FULL;
        FN_POP_HEAD, FN_POP_TAIL, FN_DELETE: if (empty) res_status_r <= ST_EMPTY;
        FN_READ: if (stat.oob) res_status_r <= ST_RANGE;
        default: ;
      endcase
    end
    if (cmd.rd_done) begin
      res_value_r <= rd_coef;
      res_power_r <= rd_pow;
    end
    if (cmd.del_chk) begin
      i_r <= i_r + CW'(1);
      if (keep) j_r <= j_r + CW'(1);
    end
    if (cmd.ev_load) begin
      tcoef_r <= rd_coef;
      e_r     <= rd_pow;
      acc_r   <= VW'(1);
      povf_r  <= 1'b0;
    end
    if (cmd.ev_pow) begin
      acc_r  <= prod[VW-1:0];
      povf_r <= povf_r | movf;
      e_r    <= e_r - PW'(1);
    end
    if (cmd.ev_mul) begin
      term_r <= prod[VW-1:0];
      ovf_r  <= ovf_r | movf | ((tcoef_r != '0) && povf_r);
    end
    if (cmd.ev_add) begin
      sum_r <= sum_add;
      ovf_r <= ovf_r | aovf;
      i_r   <= i_r + CW'(1);
    end
    if (cmd.ev_done) begin
      res_value_r <= sum_r;
      res_ovf_r   <= ovf_r;
    end
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_power_r  <= res_power_r;
      out_ovf_r    <= res_ovf_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_value    = out_value_r;
  assign out_power    = out_power_r;
  assign out_overflow = out_ovf_r;
  assign out_count    = out_count_r;
endmodule
`default_nettype wire

// ----- design/polynomial_term_store_evaluator.sv -----
// Channel  | Dir | Beat contents
// in_ch    | in  | func, coef_in, power_in, arg_in, index_in
// out_ch   | out | status, value_out, power_out, overflow, term_count_out
//
// Steps per beat, output free: append, insert, pops and unused codes load,
// execute and push; in-range reads add a wait for the RAM read data. Delete by
// key walks the list through the single-write, single-read term RAM, a read
// and a check per term. Evaluate runs all multiplies on the shared multiplier,
// per term a read, load, power loop, multiply, add; the power loop dominates.
// Reset is synchronous and empties the list; the RAM itself is not cleared.
// A finished result waits in the output register while the next beat is taken;
// the following result holds the controller until that register is free.
// Top level of the polynomial term store; depends on pte_pkg, pte_if,
// pte_ctrl and pte_datapath.
`timescale 1ns / 1ps
`default_nettype none
module polynomial_term_store_evaluator (
  input wire logic  clk,
  input wire logic  rst_n,
  pte_in_if.sink    in_ch,
  pte_out_if.source out_ch
);
  import pte_pkg::*;

  pte_cmd_t  cmd;
  pte_stat_t stat;

  pte_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  pte_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_func     (in_ch.func),
    .in_coef     (in_ch.coef_in),
    .in_power    (in_ch.power_in),
    .in_arg      (in_ch.arg_in),
    .in_index    (in_ch.index_in),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_value   (out_ch.value_out),
    .out_power   (out_ch.power_out),
    .out_overflow(out_ch.overflow),
    .out_count   (out_ch.term_count_out)
  );

  // An accepted beat keeps the block busy: the input is not ready in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice in consecutive cycles");

  // A new result is only loaded while no input beat can be taken.
  a_push_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !in_ch.ready)
    else $error("result pushed while controller idle");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == ST_FULL |-> out_ch.term_count_out == CW'(MAX_TERMS))
    else $error("full status with list not full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_ch.term_count_out <= CW'(MAX_TERMS))
    else $error("term count beyond capacity");
endmodule
`default_nettype wire
